// ===== design/rmv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared widths and defaults for the running mean and variance block.
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int COUNT_W = 32;   // sample count, also the divisor
    localparam int SUM_W   = 48;   // running sum
    localparam int MEAN_W  = 32;   // mean, fixed point
    localparam int DEV_W   = 64;   // sum of squared deviations
    localparam int VAR_W   = 48;   // variance out
    localparam int DIV_W   = DEV_W; // dividend and quotient width

endpackage
`default_nettype wire

// ===== design/rmv_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmv_div import rmv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_W-1:0]   i_dividend,
    input  wire logic [COUNT_W-1:0] i_divisor,
    output logic      [DIV_W-1:0]   o_quotient,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0]   r_quo;   // dividend shifts out, quotient shifts in
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [COUNT_W:0]   w_trial;
    logic [COUNT_W:0]   w_diff;
    logic               w_ge;
    logic [COUNT_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

// ===== design/rmv_sqr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_sqr
// Shift-and-add squarer, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rmv_sqr import rmv_pkg::*; #(
    parameter int W = 33
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [W-1:0]   i_mag,
    output logic      [2*W-1:0] o_prod
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_mcand;
    logic [W-1:0]     r_hi;
    logic [W-1:0]     r_lo;    // multiplier shifts out, low product shifts in
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [W:0] w_sum;

    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_mcand <= i_mag;
                r_hi    <= '0;
                r_lo    <= i_mag;
            end else if (r_busy) begin
                r_hi  <= w_sum[W:1];
                r_lo  <= {w_sum[0], r_lo[W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule
`default_nettype wire

// ===== design/running_mean_variance_stats_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// running_mean_variance_stats_top
// Running count, sum, min, max, Welford mean and population variance.
// ----------------------------------------------------------------------------
// Each accepted item carries one signed sample; exactly one result item
// follows it with the saturating count, the saturating 48-bit sum, the mean
// (Q.FRAC_BITS, saturating to 32 bits signed), the population variance
// (Q.FRAC_BITS, saturating to 48 bits), and the minimum and maximum so far.
// One item at a time is processed: the work is three passes through one
// bit-serial divider (count into |delta|, into the shifted square, into
// the deviation sum) at one quotient bit per cycle, 64 bits each, plus
// the start and output sequencing states. The square of delta runs on a
// shift-and-add unit alongside the first division. A finished result sits
// in the output register, so the next item can be taken while it waits
// for the consumer.
// ----------------------------------------------------------------------------
module running_mean_variance_stats_top import rmv_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    // result item
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic             [COUNT_W-1:0]     o_sample_count,
    output logic signed      [SUM_W-1:0]       o_total,
    output logic signed      [MEAN_W-1:0]      o_average,
    output logic             [VAR_W-1:0]       o_spread,
    output logic signed      [SAMPLE_BITS-1:0] o_smallest,
    output logic signed      [SAMPLE_BITS-1:0] o_largest
);

    // delta width: wide enough for x - mean without overflow
    localparam int XW  = SAMPLE_BITS + FRAC_BITS;
    localparam int MW  = ((XW > MEAN_W) ? XW : MEAN_W) + 1;
    localparam int MEW = MW + 2;        // mean update before clamping
    localparam int PW  = 2 * MW;        // square width

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_START1,   // kick squarer and |delta|/n
        S_RUN1,
        S_START2,   // sq/n
        S_RUN2,
        S_START3,   // dev/n
        S_RUN3,
        S_OUT       // hand result to the output register
    } t_state;

    t_state r_state;

    // statistics state
    logic             [COUNT_W-1:0]     r_seen;
    logic signed      [SUM_W-1:0]       r_sum;
    logic signed      [MEAN_W-1:0]      r_mean;
    logic             [DEV_W-1:0]       r_dev;
    logic signed      [SAMPLE_BITS-1:0] r_low;
    logic signed      [SAMPLE_BITS-1:0] r_high;

    // per-item working registers
    logic             [MW-1:0]          r_mag;
    logic                               r_neg;
    logic             [DEV_W-1:0]       r_sq;
    logic             [VAR_W-1:0]       r_var;

    // output register
    logic                               r_ovalid;
    logic             [COUNT_W-1:0]     r_o_count;
    logic signed      [SUM_W-1:0]       r_o_total;
    logic signed      [MEAN_W-1:0]      r_o_average;
    logic             [VAR_W-1:0]       r_o_spread;
    logic signed      [SAMPLE_BITS-1:0] r_o_smallest;
    logic signed      [SAMPLE_BITS-1:0] r_o_largest;

    // next values
    logic             [COUNT_W-1:0]     n_seen;
    logic signed      [SUM_W-1:0]       n_sum;
    logic signed      [SAMPLE_BITS-1:0] n_low;
    logic signed      [SAMPLE_BITS-1:0] n_high;
    logic             [MW-1:0]          n_mag;
    logic                               n_neg;
    logic signed      [MEAN_W-1:0]      n_mean;
    logic             [DEV_W-1:0]       n_sq;
    logic             [DEV_W-1:0]       n_dev;
    logic             [VAR_W-1:0]       n_var;

    // combinational helpers
    logic                               w_first;
    logic signed      [SUM_W:0]         w_sum_ext;
    logic signed      [MW-1:0]          w_x;
    logic signed      [MW-1:0]          w_delta;
    logic signed      [MEW-1:0]         w_q;
    logic signed      [MEW-1:0]         w_mean_ext;
    logic             [MEW-MEAN_W:0]    w_mean_top;
    logic             [DEV_W:0]         w_dev_ext;
    logic                               w_in_acc;
    logic                               w_out_acc;

    // serial units
    logic                               w_sqr_start;
    logic             [PW-1:0]          w_prod;
    logic                               w_div_start;
    logic             [DIV_W-1:0]       w_dividend;
    logic             [DIV_W-1:0]       w_quo;
    logic                               w_div_done;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = r_ovalid && i_ready;

    assign w_sqr_start = (r_state == S_START1);
    assign w_div_start = (r_state == S_START1) || (r_state == S_START2)
                      || (r_state == S_START3);

    always_comb begin
        unique case (r_state)
            S_START1: w_dividend = DIV_W'(r_mag);
            S_START2: w_dividend = r_sq;
            default:  w_dividend = r_dev;
        endcase
    end

    rmv_sqr #(
        .W (MW)
    ) u_sqr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqr_start),
        .i_mag   (r_mag),
        .o_prod  (w_prod)
    );

    rmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_seen),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // front end: count, sum, min/max, delta -- all on the accepted sample
    always_comb begin
        w_first = (r_seen == '0);
        n_seen  = (r_seen == COUNT_MAX) ? r_seen : r_seen + 1'b1;

        if (w_first) begin
            n_low  = i_sample;
            n_high = i_sample;
        end else begin
            n_low  = (i_sample < r_low)  ? i_sample : r_low;
            n_high = (i_sample > r_high) ? i_sample : r_high;
        end

        w_sum_ext = (SUM_W+1)'(r_sum) + (SUM_W+1)'(i_sample);
        if (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1]) begin
            n_sum = w_sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = w_sum_ext[SUM_W-1:0];
        end

        w_x     = MW'(i_sample) <<< FRAC_BITS;
        w_delta = w_x - MW'(r_mean);
        n_neg   = w_delta[MW-1];
        n_mag   = n_neg ? MW'(-w_delta) : MW'(w_delta);
    end

    // back end: mean clamp, shifted square, deviation sum, variance
    always_comb begin
        w_q        = signed'(MEW'(w_quo[MW-1:0]));
        w_mean_ext = r_neg ? (MEW'(r_mean) - w_q) : (MEW'(r_mean) + w_q);
        w_mean_top = w_mean_ext[MEW-1:MEAN_W-1];
        if ((&w_mean_top) || !(|w_mean_top)) begin
            n_mean = w_mean_ext[MEAN_W-1:0];
        end else begin
            n_mean = w_mean_ext[MEW-1] ? MEAN_MIN : MEAN_MAX;
        end

        // floor(mag^2 / 2^FRAC_BITS), saturating
        if (|(w_prod >> (DEV_W + FRAC_BITS))) begin
            n_sq = '1;
        end else begin
            n_sq = DEV_W'(w_prod >> FRAC_BITS);
        end

        // dev += sq - sq/n, saturating
        w_dev_ext = {1'b0, r_dev} + {1'b0, r_sq - w_quo};
        n_dev     = w_dev_ext[DEV_W] ? '1 : w_dev_ext[DEV_W-1:0];

        n_var = (|w_quo[DIV_W-1:VAR_W]) ? '1 : w_quo[VAR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_seen   <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_dev    <= '0;
            r_low    <= '0;
            r_high   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // in S_OUT a taken result is replaced by the new one below
            if (w_out_acc && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_seen  <= n_seen;
                        r_sum   <= n_sum;
                        r_low   <= n_low;
                        r_high  <= n_high;
                        r_mag   <= n_mag;
                        r_neg   <= n_neg;
                        r_state <= S_START1;
                    end
                end
                S_START1: r_state <= S_RUN1;
                S_RUN1: begin
                    // squarer is shorter than the divider, product is ready
                    if (w_div_done) begin
                        r_mean  <= n_mean;
                        r_sq    <= n_sq;
                        r_state <= S_START2;
                    end
                end
                S_START2: r_state <= S_RUN2;
                S_RUN2: begin
                    if (w_div_done) begin
                        r_dev   <= n_dev;
                        r_state <= S_START3;
                    end
                end
                S_START3: r_state <= S_RUN3;
                S_RUN3: begin
                    if (w_div_done) begin
                        r_var   <= n_var;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid     <= 1'b1;
                        r_o_count    <= r_seen;
                        r_o_total    <= r_sum;
                        r_o_average  <= r_mean;
                        r_o_spread   <= r_var;
                        r_o_smallest <= r_low;
                        r_o_largest  <= r_high;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sample_count = r_o_count;
    assign o_total        = r_o_total;
    assign o_average      = r_o_average;
    assign o_spread       = r_o_spread;
    assign o_smallest     = r_o_smallest;
    assign o_largest      = r_o_largest;

endmodule
`default_nettype wire
